[rtl/sds_pkg.sv]
// shared types and codes for the shared double stack
// used by sds_ctrl, sds_datapath and shared_double_stack; no dependencies
`default_nettype none

package sds_pkg;

	// operation carried in the input tuser field
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_NOP  = 2'd3
	} sds_kind_t;

	// result status carried in the output tuser field
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} sds_status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} sds_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the accepted item
		logic exec;   // do the stack access and count update
	} sds_cmd_t;

	localparam int unsigned IN_VALUE_BITS  = 32;
	localparam int unsigned OUT_VALUE_BITS = 32;

endpackage

`default_nettype wire

[rtl/sds_ctrl.sv]
// controller state machine for the shared double stack
// depends on sds_pkg; drives the handshakes and the datapath commands
`default_nettype none

module sds_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output sds_pkg::sds_cmd_t   cmd
);
	import sds_pkg::*;

	sds_state_t state_q;
	sds_state_t state_d;
	logic       take;

	// input item taken when idle or while the pending result leaves
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_RESP) && out_ready);
	assign take     = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (take) state_d = S_EXEC;
				else if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = take;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_RESP: begin
				out_valid = 1'b1;
				cmd.load  = take;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/sds_datapath.sv]
// datapath of the shared double stack: item registers, counts, store, result
// depends on sds_pkg; steered by sds_ctrl commands
`default_nettype none

module sds_datapath #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  sds_pkg::sds_cmd_t                           cmd,
	input  wire logic [1:0]                             in_kind,
	input  wire logic                                   in_side,
	input  wire logic [sds_pkg::IN_VALUE_BITS-1:0]      in_value,
	output sds_pkg::sds_status_t                        status,
	output logic [sds_pkg::OUT_VALUE_BITS-1:0]          read_value
);
	import sds_pkg::*;

	// only bits that can reach the 32-bit output are kept
	localparam int unsigned WB = (WORD_BITS < OUT_VALUE_BITS) ? WORD_BITS : OUT_VALUE_BITS;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] TOP   = CW'(DEPTH - 1);
	localparam logic [CW:0]   LIMIT = (CW + 1)'(DEPTH);

	logic [WB-1:0]             mem [DEPTH];
	logic [WB-1:0]             rd_q;
	sds_kind_t                 kind_q;
	logic                      side_q;
	logic [IN_VALUE_BITS-1:0]  value_q;
	logic [CW-1:0]             lower_q;
	logic [CW-1:0]             upper_q;
	sds_status_t               status_q;
	logic                      rd_sel_q;

	logic [CW:0]   total;
	logic          full;
	logic [CW-1:0] cnt;
	logic          empty;
	logic          do_push;
	logic          do_read;
	logic          do_pop;
	logic [CW-1:0] wslot;
	logic [CW-1:0] rslot;
	sds_status_t   status_d;

	// capture accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= sds_kind_t'(in_kind);
			side_q  <= in_side;
			value_q <= in_value;
		end
	end

	// decision logic for the current item
	assign total = {1'b0, lower_q} + {1'b0, upper_q};
	assign full  = (total >= LIMIT);
	assign cnt   = side_q ? upper_q : lower_q;
	assign empty = (cnt == '0);

	always_comb begin
		do_push  = 1'b0;
		do_read  = 1'b0;
		do_pop   = 1'b0;
		status_d = ST_DONE;
		case (kind_q)
			KIND_PUSH: begin
				if (full) status_d = ST_FULL;
				else do_push = 1'b1;
			end
			KIND_POP, KIND_PEEK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					do_read = 1'b1;
					do_pop  = (kind_q == KIND_POP);
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// slot of the next free word and of the top word on the chosen side
	assign wslot = side_q ? (TOP - upper_q) : lower_q;
	assign rslot = side_q ? (TOP - upper_q + CW'(1)) : (lower_q - CW'(1));

	// store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) begin
			mem[wslot[AW-1:0]] <= value_q[WB-1:0];
		end
		if (cmd.exec) begin
			rd_q <= mem[rslot[AW-1:0]];
		end
	end

	// stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (cmd.exec) begin
			if (do_push) begin
				if (side_q) upper_q <= upper_q + CW'(1);
				else lower_q <= lower_q + CW'(1);
			end else if (do_pop) begin
				if (side_q) upper_q <= upper_q - CW'(1);
				else lower_q <= lower_q - CW'(1);
			end
		end
	end

	// result status register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			rd_sel_q <= do_read;
		end
	end

	assign status     = status_q;
	assign read_value = rd_sel_q ? OUT_VALUE_BITS'(rd_q) : '0;

endmodule

`default_nettype wire

[rtl/shared_double_stack.sv]
// Two stacks in one store of DEPTH words: the lower stack grows up from entry 0 and the
// upper stack grows down from entry DEPTH-1. Each input item is a push, pop, peek or no-op on one
// side and gives exactly one result item with a status (done, full, empty) and the popped
// or peeked word (zero otherwise). Refused operations change nothing. For each item the counts
// are first looked up and the store accessed, with the read data registered, and then the result
// is offered; the next item is taken in the cycle the result is taken, so a new item is not
// accepted before the last result leaves. Words wider than 32 bits
// are held only to 32 bits, since no more can reach the output. The store has no reset;
// an entry's word only reaches the output after it has been pushed.
// depends on sds_pkg, sds_ctrl and sds_datapath
`default_nettype none

module shared_double_stack #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
	input  wire logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] read_value
	output logic [1:0]       m_axis_tuser    // [1:0] status
);
	import sds_pkg::*;

	sds_cmd_t    cmd;
	sds_status_t status;

	// control
	sds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// storage and counts
	sds_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_kind    (s_axis_tuser[1:0]),
		.in_side    (s_axis_tuser[2]),
		.in_value   (s_axis_tdata),
		.status     (status),
		.read_value (m_axis_tdata)
	);

	assign m_axis_tuser = status;

endmodule

`default_nettype wire

[tb/sv/shared_double_stack_test.sv]
// self-checking testbench for shared_double_stack: pushes, pops and peeks on both stacks,
// each result checked against a cycle-free software copy of the two stacks
// depends on sds_pkg and shared_double_stack
`timescale 1ns / 1ps

module shared_double_stack_test;
	import sds_pkg::*;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned RANDOM_OPS = 1400;

	// one operation on the input stream
	typedef struct {
		sds_kind_t   kind;
		logic        side;
		logic [31:0] value;
	} stack_op_t;

	// one result on the output stream
	typedef struct {
		sds_status_t status;
		logic [31:0] word;
	} stack_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] push_value
	logic [2:0]  s_axis_tuser = '0;   // [1:0] kind, [2] side
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] read_value
	logic [1:0]  m_axis_tuser;        // [1:0] status

	// operations waiting to be sent and results waiting to arrive
	stack_op_t     pending_ops[$];
	stack_result_t expected_results[$];
	stack_op_t     offered_op;

	// software copy of the shared store and both stack heights
	logic [31:0] stack_words[DEPTH];
	int unsigned lower_height = 0;
	int unsigned upper_height = 0;

	int total_ops = 0;
	int accepted_ops = 0;
	int received_results = 0;
	int errors = 0;
	int n_push = 0, n_pop = 0, n_peek = 0, n_nop = 0;
	int n_done = 0, n_full = 0, n_empty = 0;

	shared_double_stack #(
		.DEPTH(DEPTH),
		.WORD_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one operation to the software stacks and return its result
	function automatic stack_result_t apply_stack_op(stack_op_t op);
		stack_result_t res;
		int unsigned height;
		int unsigned slot;
		res.status = ST_DONE;
		res.word = '0;
		height = op.side ? upper_height : lower_height;
		case (op.kind)
			KIND_PUSH: begin
				n_push++;
				if (lower_height + upper_height >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slot = op.side ? DEPTH - 1 - height : height;
					stack_words[slot] = op.value;
					if (op.side) upper_height++;
					else lower_height++;
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (op.kind == KIND_POP) n_pop++;
				else n_peek++;
				if (height == 0) begin
					res.status = ST_EMPTY;
				end else begin
					slot = op.side ? DEPTH - height : height - 1;
					res.word = stack_words[slot];
					if (op.kind == KIND_POP) begin
						if (op.side) upper_height--;
						else lower_height--;
					end
				end
			end
			default: n_nop++;
		endcase
		case (res.status)
			ST_FULL: n_full++;
			ST_EMPTY: n_empty++;
			default: n_done++;
		endcase
		return res;
	endfunction

	// idle percentages: sender light / receiver heavy, then swapped, then none
	function automatic int unsigned idle_pct(bit receiver);
		if (accepted_ops < total_ops / 3) return receiver ? 50 : 25;
		if (accepted_ops < 2 * total_ops / 3) return receiver ? 25 : 50;
		return 0;
	endfunction

	task automatic add_op(sds_kind_t kind, logic side, logic [31:0] value);
		stack_op_t op;
		op.kind = kind;
		op.side = side;
		op.value = value;
		pending_ops.push_back(op);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// input driver: predicts each accepted item, then offers the next one
	always @(posedge clk) begin
		bit fire;
		fire = s_axis_tvalid && s_axis_tready;
		if (fire) begin
			expected_results.push_back(apply_stack_op(offered_op));
			accepted_ops++;
		end
		if (!s_axis_tvalid || fire) begin
			if (arst_n && pending_ops.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
				offered_op = pending_ops.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= offered_op.value;
				s_axis_tuser <= {offered_op.side, offered_op.kind};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				received_results++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d read_value %h", m_axis_tuser,
						m_axis_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata !== want.word) begin
						$error("read_value: expected %h, got %h", want.word, m_axis_tdata);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	// stimulus and end of run
	initial begin
		int made;
		int burst_len;
		int mode;
		int push_pct;
		logic bias_side;
		logic side;
		sds_kind_t kind;

		// both sides empty, the unused kind, extreme words
		add_op(KIND_POP, 1'b0, 32'hFFFF_FFFF);
		add_op(KIND_PEEK, 1'b1, 32'h0000_0000);
		add_op(KIND_NOP, 1'b1, 32'hFFFF_FFFF);
		add_op(KIND_PUSH, 1'b0, 32'h7FFF_FFFF);
		add_op(KIND_PUSH, 1'b1, 32'h8000_0000);
		add_op(KIND_PEEK, 1'b0, 32'h0000_0000);
		add_op(KIND_POP, 1'b1, 32'h0000_0000);
		// fill the store from both ends until the stacks meet
		for (int i = 0; i < 15; i++) begin
			add_op(KIND_PUSH, i[0], (i % 3 == 0) ? 32'hFFFF_FFFF : $urandom);
		end
		// store full: pushes on either side are refused
		add_op(KIND_PUSH, 1'b1, 32'h0000_0001);
		add_op(KIND_PUSH, 1'b0, 32'hFFFF_FFFE);
		add_op(KIND_PEEK, 1'b1, 32'h0000_0000);

		// random bursts that lean toward filling, draining or neither
		made = 0;
		while (made < RANDOM_OPS) begin
			mode = $urandom_range(2);
			burst_len = $urandom_range(40, 8);
			bias_side = 1'($urandom_range(1));
			push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			for (int i = 0; i < burst_len; i++) begin
				if ($urandom_range(99) < 3) begin
					add_op(KIND_NOP, 1'($urandom_range(1)), random_word());
				end else begin
					side = ($urandom_range(99) < 70) ? bias_side : !bias_side;
					if ($urandom_range(99) < push_pct) kind = KIND_PUSH;
					else kind = ($urandom_range(2) == 0) ? KIND_PEEK : KIND_POP;
					add_op(kind, side, random_word());
					made++;
				end
			end
		end
		total_ops = pending_ops.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_ops < total_ops) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		// catch any stray result after the last expected one
		repeat (8) @(posedge clk);

		$display("%0d items: %0d pushes, %0d pops, %0d peeks, %0d no-ops",
			total_ops, n_push, n_pop, n_peek, n_nop);
		$display("%0d results: %0d done, %0d refused full, %0d refused empty",
			received_results, n_done, n_full, n_empty);
		if (errors == 0) begin
			$display("shared_double_stack_test: done, clean");
		end else begin
			$display("shared_double_stack_test: done, errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("shared_double_stack_test: done, errors");
		$finish;
	end

endmodule
